// ===== sv/dik_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta inverse kinematics package
// Shared widths, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package dik_pkg;

   localparam int CoordWidth  = 21;
   localparam int RodWidth    = 40;
   localparam int HeightWidth = 22;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 40;
   localparam int RadWidth    = 41;
   localparam int RootWidth   = 20;
   localparam int QueueDepth  = 2;

   localparam logic [CsrIdxWidth-1:0] REG_ROD_SQ = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_T1_X   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_T1_Y   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_T2_X   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_T2_Y   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_T3_Y   = 3'd5;

   typedef struct packed {
      logic [RadWidth-2:0]   rad_one;
      logic [RadWidth-2:0]   rad_two;
      logic [RadWidth-2:0]   rad_three;
      logic signed [CoordWidth-1:0] pos_z;
      logic                  unreachable;
   } entry_type;

endpackage

// ===== sv/delta_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// Delta inverse kinematics
// Turns a Cartesian point into the three carriage heights of a linear delta.
//
// Channel  Direction  Contents
// req_     in         pos_x, pos_y, pos_z
// rsp_     out        height_one, height_two, height_three, unreachable
// csr_     in         register index and write data
//
// One point is accepted per cycle while no stalled result backs up; rsp_valid
// rises once the request has passed through two front stages, one queue entry
// and the square root pipeline that resolves one root bit per stage.
// Reset clears the geometry registers to zero and empties every stage.
// A stalled result backs up stage by stage into the queue and the front end.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics #(
   parameter int QueueDepth = dik_pkg::QueueDepth
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_x,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_y,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dik_pkg::HeightWidth-1:0]  rsp_height_one,
   output logic signed [dik_pkg::HeightWidth-1:0]  rsp_height_two,
   output logic signed [dik_pkg::HeightWidth-1:0]  rsp_height_three,
   output logic                                    rsp_unreachable,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [dik_pkg::CsrIdxWidth-1:0]         csr_index,
   input  logic [dik_pkg::CsrDatWidth-1:0]         csr_data
);
   import dik_pkg::*;

   logic [RodWidth-1:0]          rod_ff;
   logic signed [CoordWidth-1:0] t1x_ff, t1y_ff, t2x_ff, t2y_ff, t3y_ff;
   logic                         fq_valid, fq_ready, qb_valid, qb_ready;
   entry_type                    fq_entry, qb_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rod_ff <= '0;
         t1x_ff <= '0;
         t1y_ff <= '0;
         t2x_ff <= '0;
         t2y_ff <= '0;
         t3y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROD_SQ: rod_ff <= csr_data[RodWidth-1:0];
            REG_T1_X:   t1x_ff <= csr_data[CoordWidth-1:0];
            REG_T1_Y:   t1y_ff <= csr_data[CoordWidth-1:0];
            REG_T2_X:   t2x_ff <= csr_data[CoordWidth-1:0];
            REG_T2_Y:   t2y_ff <= csr_data[CoordWidth-1:0];
            REG_T3_Y:   t3y_ff <= csr_data[CoordWidth-1:0];
            default: ;
         endcase
      end
   end

   dik_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_pos_x, .req_pos_y, .req_pos_z,
      .rod_sq(rod_ff), .t1_x(t1x_ff), .t1_y(t1y_ff), .t2_x(t2x_ff), .t2_y(t2y_ff),
      .t3_y(t3y_ff), .out_valid(fq_valid), .out_ready(fq_ready), .out_entry(fq_entry)
   );

   dik_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_entry(fq_entry),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_entry(qb_entry)
   );

   dik_back u_back (
      .clock, .reset, .in_valid(qb_valid), .in_ready(qb_ready), .in_entry(qb_entry),
      .rsp_valid, .rsp_ready, .rsp_height_one, .rsp_height_two, .rsp_height_three,
      .rsp_unreachable
   );

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unreachable |-> rsp_height_one == '0 && rsp_height_two == '0
                                       && rsp_height_three == '0)
      else $error("unreachable result with nonzero height");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height_one))
      else $error("stalled result changed");
endmodule

// ===== sv/dik_front.sv =====
// ----------------------------------------------------------------------------
// Delta inverse kinematics front end
// Accepts points, forms the three radicands over two stages and flags
// unreachable points.
// ----------------------------------------------------------------------------
module dik_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_x,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_y,
   input  logic signed [dik_pkg::CoordWidth-1:0]   req_pos_z,
   input  logic        [dik_pkg::RodWidth-1:0]     rod_sq,
   input  logic signed [dik_pkg::CoordWidth-1:0]   t1_x,
   input  logic signed [dik_pkg::CoordWidth-1:0]   t1_y,
   input  logic signed [dik_pkg::CoordWidth-1:0]   t2_x,
   input  logic signed [dik_pkg::CoordWidth-1:0]   t2_y,
   input  logic signed [dik_pkg::CoordWidth-1:0]   t3_y,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output dik_pkg::entry_type                      out_entry
);
   import dik_pkg::*;

   localparam int DW = CoordWidth + 1;
   localparam int PW = 2 * DW;

   logic                   s1_valid_ff, s1_valid_in;
   logic signed [PW-1:0]   sq_ff [6];
   logic signed [PW-1:0]   sq_in [6];
   logic [RodWidth-1:0]    rod_ff;
   logic signed [CoordWidth-1:0] z1_ff;
   logic                   s2_valid_ff, s2_valid_in;
   entry_type              ent_ff, ent_in;
   logic signed [DW-1:0]   d [6];
   logic signed [PW+1:0]   rad [3];
   logic                   adv2, adv1;

   assign adv2 = !s2_valid_ff || out_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   always_comb begin
      d[0] = DW'(t1_x) - DW'(req_pos_x);
      d[1] = DW'(t1_y) - DW'(req_pos_y);
      d[2] = DW'(t2_x) - DW'(req_pos_x);
      d[3] = DW'(t2_y) - DW'(req_pos_y);
      d[4] = -DW'(req_pos_x);
      d[5] = DW'(t3_y) - DW'(req_pos_y);
      for (int i = 0; i < 6; i++) begin
         sq_in[i] = d[i] * d[i];
      end
      for (int t = 0; t < 3; t++) begin
         rad[t] = $signed({2'b00, rod_ff}) - (PW+2)'(sq_ff[2*t]) - (PW+2)'(sq_ff[2*t+1]);
      end
      ent_in.rad_one     = rad[0][RadWidth-2:0];
      ent_in.rad_two     = rad[1][RadWidth-2:0];
      ent_in.rad_three   = rad[2][RadWidth-2:0];
      ent_in.pos_z       = z1_ff;
      ent_in.unreachable = rad[0][PW+1] | rad[1][PW+1] | rad[2][PW+1];
      s1_valid_in = adv1 ? req_valid : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (adv1) begin
         sq_ff  <= sq_in;
         rod_ff <= rod_sq;
         z1_ff  <= req_pos_z;
      end
      if (adv2) begin
         ent_ff <= ent_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_entry = ent_ff;
endmodule

// ===== sv/dik_queue.sv =====
// ----------------------------------------------------------------------------
// Delta inverse kinematics queue
// Short register queue between the front end and the root pipeline.
// ----------------------------------------------------------------------------
module dik_queue #(
   parameter int Depth = dik_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  dik_pkg::entry_type in_entry,
   output logic               out_valid,
   input  logic               out_ready,
   output dik_pkg::entry_type out_entry
);
   import dik_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   entry_type         mem_ff [Depth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_entry = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push) wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_entry;
   end
endmodule

// ===== sv/dik_back.sv =====
// ----------------------------------------------------------------------------
// Delta inverse kinematics back end
// Pipelined integer square roots, one result bit per stage, then the height
// sums, or zeros for an unreachable point, in the output register.
// ----------------------------------------------------------------------------
module dik_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  dik_pkg::entry_type                    in_entry,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dik_pkg::HeightWidth-1:0] rsp_height_one,
   output logic signed [dik_pkg::HeightWidth-1:0] rsp_height_two,
   output logic signed [dik_pkg::HeightWidth-1:0] rsp_height_three,
   output logic                                  rsp_unreachable
);
   import dik_pkg::*;

   localparam int NS = RootWidth;
   localparam int VW = RadWidth - 1;
   localparam int RW = RootWidth;

   logic                          vld_ff [NS+1];
   logic [VW-1:0]                 rem_ff [NS+1][3];
   logic [RW-1:0]                 root_ff [NS+1][3];
   logic signed [CoordWidth-1:0]  z_ff [NS+1];
   logic                          un_ff [NS+1];
   logic                          adv [NS+1];
   logic [VW-1:0]                 rem_in [NS][3];
   logic [RW-1:0]                 root_in [NS][3];
   logic                          ov_ff;
   logic signed [HeightWidth-1:0] h_ff [3];
   logic signed [HeightWidth-1:0] h_in [3];
   logic                          ou_ff;

   always_comb begin
      adv[NS] = !ov_ff || rsp_ready;
      for (int s = NS - 1; s >= 0; s--) begin
         adv[s] = !vld_ff[s+1] || adv[s+1];
      end
   end
   assign in_ready = !vld_ff[0] || adv[0];

   always_comb begin
      logic [VW-1:0] trial;
      for (int s = 0; s < NS; s++) begin
         for (int t = 0; t < 3; t++) begin
            trial = (VW'(root_ff[s][t]) << (NS - s)) | (VW'(1) << (2 * (NS - 1 - s)));
            if (rem_ff[s][t] >= trial) begin
               rem_in[s][t]  = rem_ff[s][t] - trial;
               root_in[s][t] = root_ff[s][t] | (RW'(1) << (NS - 1 - s));
            end else begin
               rem_in[s][t]  = rem_ff[s][t];
               root_in[s][t] = root_ff[s][t];
            end
         end
      end
      for (int t = 0; t < 3; t++) begin
         h_in[t] = un_ff[NS] ? '0 :
                   HeightWidth'(root_ff[NS][t]) + HeightWidth'(z_ff[NS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) vld_ff[s] <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (in_ready) vld_ff[0] <= in_valid;
         for (int s = 0; s < NS; s++) begin
            if (adv[s]) vld_ff[s+1] <= vld_ff[s];
         end
         if (adv[NS]) ov_ff <= vld_ff[NS];
      end
      if (in_ready) begin
         rem_ff[0][0]  <= in_entry.rad_one;
         rem_ff[0][1]  <= in_entry.rad_two;
         rem_ff[0][2]  <= in_entry.rad_three;
         root_ff[0][0] <= '0;
         root_ff[0][1] <= '0;
         root_ff[0][2] <= '0;
         z_ff[0]       <= in_entry.pos_z;
         un_ff[0]      <= in_entry.unreachable;
      end
      for (int s = 0; s < NS; s++) begin
         if (adv[s]) begin
            rem_ff[s+1]  <= rem_in[s];
            root_ff[s+1] <= root_in[s];
            z_ff[s+1]    <= z_ff[s];
            un_ff[s+1]   <= un_ff[s];
         end
      end
      if (adv[NS]) begin
         h_ff  <= h_in;
         ou_ff <= un_ff[NS];
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_height_one   = h_ff[0];
   assign rsp_height_two   = h_ff[1];
   assign rsp_height_three = h_ff[2];
   assign rsp_unreachable  = ou_ff;
endmodule

// ===== dv/dik_heights_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta carriage height checker
// Watches the request, response and register channels of the delta inverse
// kinematics block, computes the three carriage heights of every accepted
// point from its own copy of the geometry registers, and compares each
// response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dik_heights_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [dik_pkg::CoordWidth-1:0]  req_pos_x,
   input  logic signed [dik_pkg::CoordWidth-1:0]  req_pos_y,
   input  logic signed [dik_pkg::CoordWidth-1:0]  req_pos_z,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [dik_pkg::HeightWidth-1:0] rsp_height_one,
   input  logic signed [dik_pkg::HeightWidth-1:0] rsp_height_two,
   input  logic signed [dik_pkg::HeightWidth-1:0] rsp_height_three,
   input  logic                                   rsp_unreachable,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [dik_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [dik_pkg::CsrDatWidth-1:0]        csr_data,
   output int                                     fail_count,
   output int                                     pending_heights,
   output int                                     checked_count,
   output int                                     unreachable_count
);
   import dik_pkg::*;

   typedef struct packed {
      logic signed [HeightWidth-1:0] height_one;
      logic signed [HeightWidth-1:0] height_two;
      logic signed [HeightWidth-1:0] height_three;
      logic                          unreachable;
   } carriage_heights_type;

   logic [RodWidth-1:0]          rod_sq;
   logic signed [CoordWidth-1:0] t1_x, t1_y, t2_x, t2_y, t3_y;
   carriage_heights_type         expected_heights[$];

   function automatic longint unsigned floor_sqrt(input longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic longint tower_radicand(input logic signed [CoordWidth-1:0] tower_x,
                                             input logic signed [CoordWidth-1:0] tower_y,
                                             input logic signed [CoordWidth-1:0] px,
                                             input logic signed [CoordWidth-1:0] py);
      longint dx;
      longint dy;
      dx = longint'(tower_x) - longint'(px);
      dy = longint'(tower_y) - longint'(py);
      return longint'({24'd0, rod_sq}) - (dx * dx + dy * dy);
   endfunction

   function automatic carriage_heights_type predict_heights(
      input logic signed [CoordWidth-1:0] px,
      input logic signed [CoordWidth-1:0] py,
      input logic signed [CoordWidth-1:0] pz);
      carriage_heights_type result;
      longint               rad_one, rad_two, rad_three;
      longint               sum;
      rad_one   = tower_radicand(t1_x, t1_y, px, py);
      rad_two   = tower_radicand(t2_x, t2_y, px, py);
      rad_three = tower_radicand('0, t3_y, px, py);
      result = '0;
      if (rad_one < 0 || rad_two < 0 || rad_three < 0) begin
         result.unreachable = 1'b1;
      end else begin
         sum = longint'(floor_sqrt(rad_one)) + longint'(pz);
         result.height_one = sum[HeightWidth-1:0];
         sum = longint'(floor_sqrt(rad_two)) + longint'(pz);
         result.height_two = sum[HeightWidth-1:0];
         sum = longint'(floor_sqrt(rad_three)) + longint'(pz);
         result.height_three = sum[HeightWidth-1:0];
      end
      return result;
   endfunction

   always @(posedge clock) begin
      carriage_heights_type want;
      if (reset) begin
         rod_sq = '0;
         t1_x = '0;
         t1_y = '0;
         t2_x = '0;
         t2_y = '0;
         t3_y = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROD_SQ: rod_sq = csr_data[RodWidth-1:0];
               REG_T1_X:   t1_x = csr_data[CoordWidth-1:0];
               REG_T1_Y:   t1_y = csr_data[CoordWidth-1:0];
               REG_T2_X:   t2_x = csr_data[CoordWidth-1:0];
               REG_T2_Y:   t2_y = csr_data[CoordWidth-1:0];
               REG_T3_Y:   t3_y = csr_data[CoordWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_heights.size() == 0) begin
               $error("Response arrived with no request outstanding.");
               fail_count++;
            end else begin
               want = expected_heights.pop_front();
               checked_count++;
               if (want.unreachable) begin
                  unreachable_count++;
               end
               if (rsp_height_one !== want.height_one) begin
                  $error("height_one: expected %0d, got %0d", want.height_one,
                         rsp_height_one);
                  fail_count++;
               end
               if (rsp_height_two !== want.height_two) begin
                  $error("height_two: expected %0d, got %0d", want.height_two,
                         rsp_height_two);
                  fail_count++;
               end
               if (rsp_height_three !== want.height_three) begin
                  $error("height_three: expected %0d, got %0d", want.height_three,
                         rsp_height_three);
                  fail_count++;
               end
               if (rsp_unreachable !== want.unreachable) begin
                  $error("unreachable: expected %0d, got %0d", want.unreachable,
                         rsp_unreachable);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_heights.push_back(predict_heights(req_pos_x, req_pos_y, req_pos_z));
         end
      end
      pending_heights = expected_heights.size();
   end

   initial begin
      fail_count = 0;
      pending_heights = 0;
      checked_count = 0;
      unreachable_count = 0;
   end

endmodule

// ===== dv/delta_inverse_kinematics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta inverse kinematics testbench
// Programs several tower geometries, from all zero to full scale, and streams
// directed and random nozzle points through the block with bursty requests
// and a stalling receiver; a checker predicts and compares every response.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics_tb;
   import dik_pkg::*;

   localparam logic [CsrIdxWidth-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CsrIdxWidth-1:0] REG_SPARE_HI = 3'd7;
   localparam int IdleLimit   = 3000;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 40;
   localparam logic signed [CoordWidth-1:0] CoordMin = CoordWidth'(-(1 <<< (CoordWidth - 1)));
   localparam logic signed [CoordWidth-1:0] CoordMax = CoordWidth'((1 <<< (CoordWidth - 1)) - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CoordWidth-1:0] req_pos_x = '0;
   logic signed [CoordWidth-1:0] req_pos_y = '0;
   logic signed [CoordWidth-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [HeightWidth-1:0] rsp_height_one, rsp_height_two, rsp_height_three;
   logic rsp_unreachable;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDatWidth-1:0] csr_data = '0;

   int fail_count, pending_heights, checked_count, unreachable_count;
   int burst_left = 0;
   int idle_cycles = 0;
   int geometry_count = 0;
   bit hold_request = 1'b0;

   delta_inverse_kinematics i_dut (.*);

   dik_heights_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: a stall pattern that changes every so often, plus one long hold.
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= mode_left[0];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAIL delta_inverse_kinematics");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CsrIdxWidth-1:0] index,
                            input logic [CsrDatWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_coord(input logic [CsrIdxWidth-1:0] index,
                              input logic signed [CoordWidth-1:0] value);
      logic [CsrDatWidth-1:0] data;
      data = CsrDatWidth'({$urandom, $urandom});
      data[CoordWidth-1:0] = value;
      write_reg(index, data);
   endtask

   task automatic set_geometry(input logic [RodWidth-1:0] rod_sq,
                               input logic signed [CoordWidth-1:0] x1, y1, x2, y2, y3);
      write_reg(REG_ROD_SQ, rod_sq);
      write_coord(REG_T1_X, x1);
      write_coord(REG_T1_Y, y1);
      write_coord(REG_T2_X, x2);
      write_coord(REG_T2_Y, y2);
      write_coord(REG_T3_Y, y3);
      geometry_count++;
   endtask

   task automatic send_point(input logic signed [CoordWidth-1:0] x, y, z);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (pending_heights != 0);
      @(posedge clock);
   endtask

   function automatic logic signed [CoordWidth-1:0] near_coord(input int span);
      return CoordWidth'($urandom_range(0, 2 * span) - span);
   endfunction

   initial begin
      int radius;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All-zero geometry: only the origin column is reachable, with zero roots.
      send_point(0, 0, CoordMin);
      send_point(0, 0, CoordMax);
      send_point(0, 0, 0);
      send_point(1, 0, 0);
      send_point(CoordMin, CoordMax, 5);
      wait_drained();

      write_reg(REG_SPARE_LO, CsrDatWidth'({$urandom, $urandom}));
      write_reg(REG_SPARE_HI, CsrDatWidth'({$urandom, $urandom}));
      set_geometry(40'd62500000000, -129904, -75000, 129904, -75000, 150000);
      send_point(0, 0, 0);
      send_point(0, 0, CoordMin);
      send_point(0, 0, CoordMax);
      send_point(0, 150000 - 250000, 1000);
      send_point(100000, 100000, -300);
      send_point(CoordMax, CoordMax, CoordMax);
      wait_drained();

      set_geometry({RodWidth{1'b1}}, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin);
      send_point(CoordMin, CoordMin, CoordMin);
      send_point(CoordMax, CoordMax, CoordMax);
      send_point(CoordMin, CoordMax, CoordMax);
      send_point(CoordMax, CoordMin, CoordMin);
      send_point(0, 0, CoordMax);
      send_point(0, 0, CoordMin);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         radius = $urandom_range(20000, 1000000);
         case (phase % 4)
            0: set_geometry(RodWidth'(longint'(radius) * radius),
                            CoordWidth'(-(radius * 433) / 1000), CoordWidth'(-radius / 4),
                            CoordWidth'((radius * 433) / 1000), CoordWidth'(-radius / 4),
                            CoordWidth'(radius / 2));
            1: set_geometry(RodWidth'(longint'(radius) * radius
                                      + longint'($urandom_range(0, 1000))),
                            near_coord(radius / 2), near_coord(radius / 2),
                            near_coord(radius / 2), near_coord(radius / 2),
                            near_coord(radius / 2));
            2: set_geometry(RodWidth'({$urandom, $urandom}), CoordWidth'($urandom),
                            CoordWidth'($urandom), CoordWidth'($urandom),
                            CoordWidth'($urandom), CoordWidth'($urandom));
            default: set_geometry({RodWidth{1'b1}}, CoordMax, CoordMin, CoordMin,
                                  CoordMax, CoordMax);
         endcase
         if (phase == 1) begin
            hold_request = 1'b1;
         end
         repeat (135) begin
            if ($urandom_range(0, 4) == 0) begin
               send_point(CoordWidth'($urandom), CoordWidth'($urandom),
                          CoordWidth'($urandom));
            end else begin
               send_point(near_coord(radius / 3), near_coord(radius / 3),
                          CoordWidth'($urandom));
            end
         end
         wait_drained();
      end

      repeat (DrainCycles) @(posedge clock);
      $display("Checked %0d points over %0d tower geometries, %0d of them unreachable.",
               checked_count, geometry_count, unreachable_count);
      if (fail_count == 0) begin
         $display("PASS delta_inverse_kinematics");
      end else begin
         $display("FAIL delta_inverse_kinematics");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dik_pkg.sv
sv/dik_front.sv
sv/dik_queue.sv
sv/dik_back.sv
sv/delta_inverse_kinematics.sv
dv/dik_heights_checker.sv
dv/delta_inverse_kinematics_tb.sv
